[design/spp_pkg.sv]
// Shared opcodes, mark classes and fixed-point constants for the scatter point plotter.
`timescale 1ns / 1ps
`default_nettype none

package spp_pkg;

  // Item opcodes; code 3 is unused and answers with a zero pixel.
  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Mark classes; codes 5..7 leave the pixel as it is.
  localparam logic [2:0] CLS_BORDER  = 3'd0;
  localparam logic [2:0] CLS_DENSITY = 3'd1;
  localparam logic [2:0] CLS_BLUE    = 3'd2;
  localparam logic [2:0] CLS_GREEN   = 3'd3;
  localparam logic [2:0] CLS_RED     = 3'd4;

  // Q2.14 coordinates.
  localparam int Q_FRAC = 14;
  localparam int Q_ONE  = 16384;

  localparam logic [7:0] BYTE_FULL = 8'hFF;

endpackage

`default_nettype wire

[design/spp_axis_map.sv]
// One axis of the coordinate mapper: scale, truncate and clamp to a pixel index.
`timescale 1ns / 1ps
`default_nettype none

module spp_axis_map import spp_pkg::*; #(
  parameter int LIMIT      = 400,
  parameter int HALF_SCALE = 200,
  parameter int IDX_W      = 9
) (
  input  logic                clk,
  input  logic signed [16:0]  offset,  // coordinate shifted by one, Q3.14
  output logic [IDX_W-1:0]    idx
);

  localparam int SCALE_W = $clog2(HALF_SCALE + 1);
  localparam int PROD_W  = 16 + SCALE_W;

  logic [PROD_W-1:0] prod;
  logic [31:0]       quo;

  // stage 1: non-positive offsets map to index zero
  always_ff @(posedge clk) begin
    if (!offset[16] && (offset != 17'sd0)) begin
      prod <= PROD_W'(offset[15:0]) * PROD_W'(HALF_SCALE);
    end else begin
      prod <= '0;
    end
  end

  assign quo = 32'(prod >> Q_FRAC);

  // stage 2: clamp to the last index
  always_ff @(posedge clk) begin
    if (quo >= 32'(LIMIT)) begin
      idx <= IDX_W'(LIMIT - 1);
    end else begin
      idx <= quo[IDX_W-1:0];
    end
  end

endmodule

`default_nettype wire

[design/spp_frame_ram.sv]
// Single-port-write, registered-read pixel memory.
`timescale 1ns / 1ps
`default_nettype none

module spp_frame_ram #(
  parameter int DEPTH  = 160000,
  parameter int ADDR_W = 18
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [23:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [23:0]       rdata
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/scatter_point_plotter_core.sv]
// Scatter point plotter top level: controller, coordinate mapper and frame memory.
// Results: done follows WRITE for a plot (MAP, CLAMP, ADDR, READ, WRITE) and a read
//   (ADDR, READ, WRITE), the last pixel for a clear, and the accept otherwise.
// Throughput: one item at a time; busy stays high until the item's pass through the
//   frame memory, or a clear's pass over it, ends.
// Reset: a clearing pass zeroes the memory, one pixel per cycle, with busy high;
//   it reports no result.
`timescale 1ns / 1ps
`default_nettype none

module scatter_point_plotter_core import spp_pkg::*; #(
  parameter int IMG_WIDTH  = 400,
  parameter int IMG_HEIGHT = 400,
  parameter int HALF_SCALE = 200
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [2:0]         mark_class,
  input  logic [8:0]         read_col,
  input  logic [8:0]         read_row,
  output logic               done,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  localparam int DEPTH  = IMG_WIDTH * IMG_HEIGHT;
  localparam int COL_W  = $clog2(IMG_WIDTH);
  localparam int ROW_W  = $clog2(IMG_HEIGHT);
  localparam int ADDR_W = $clog2(DEPTH);

  // One-hot controller states. A plot walks MAP -> CLAMP -> ADDR -> READ -> WRITE;
  // a read enters at ADDR with its saturated position.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MAP   = 7'b0000010,
    S_CLAMP = 7'b0000100,
    S_ADDR  = 7'b0001000,
    S_READ  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_CLEAR = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic               accept;
  logic               is_plot;     // transaction in flight is a plot
  logic               clr_report;  // clear came from an item, not from reset
  logic [ADDR_W-1:0]  clr_addr;
  logic signed [15:0] x_q;
  logic signed [15:0] y_q;
  logic [2:0]         cls_q;
  logic [COL_W-1:0]   rd_col_q;
  logic [ROW_W-1:0]   rd_row_q;
  logic [ADDR_W-1:0]  addr_q;

  logic signed [16:0] x_off;
  logic signed [16:0] y_off;
  logic [COL_W-1:0]   map_col;
  logic [ROW_W-1:0]   map_row;
  logic [COL_W-1:0]   col_sel;
  logic [ROW_W-1:0]   row_sel;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [23:0]        ram_wdata;
  logic [23:0]        ram_rdata;
  logic [23:0]        px_new;
  logic [7:0]         r_dec;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // ---------------------------------------------------------------
  // Coordinate mapping: column from x+1, row from 1-y (y is up).
  // ---------------------------------------------------------------
  assign x_off = {x_q[15], x_q} + 17'(Q_ONE);
  assign y_off = 17'(Q_ONE) - {y_q[15], y_q};

  spp_axis_map #(
    .LIMIT      (IMG_WIDTH),
    .HALF_SCALE (HALF_SCALE),
    .IDX_W      (COL_W)
  ) u_map_col (
    .clk    (clk),
    .offset (x_off),
    .idx    (map_col)
  );

  spp_axis_map #(
    .LIMIT      (IMG_HEIGHT),
    .HALF_SCALE (HALF_SCALE),
    .IDX_W      (ROW_W)
  ) u_map_row (
    .clk    (clk),
    .offset (y_off),
    .idx    (map_row)
  );

  assign col_sel = is_plot ? map_col : rd_col_q;
  assign row_sel = is_plot ? map_row : rd_row_q;

  // ---------------------------------------------------------------
  // Frame memory. Reads are free running at the held address; the
  // data used in WRITE is the pixel as it stood before this item.
  // ---------------------------------------------------------------
  assign ram_we    = (state == S_CLEAR) || ((state == S_WRITE) && is_plot);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : addr_q;
  assign ram_wdata = (state == S_CLEAR) ? 24'd0 : px_new;

  spp_frame_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_q),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------
  // Pixel update by mark class. Density counts red down, skipping 0.
  // ---------------------------------------------------------------
  assign r_dec = ram_rdata[23:16] - 8'd1;

  always_comb begin
    px_new = ram_rdata;
    if (is_plot) begin
      case (cls_q)
        CLS_BORDER:  px_new = {BYTE_FULL, BYTE_FULL, ram_rdata[7:0]};
        CLS_DENSITY: px_new = {((r_dec == 8'd0) ? 8'd1 : r_dec), BYTE_FULL, BYTE_FULL};
        CLS_BLUE:    px_new = {8'd0, 8'd0, BYTE_FULL};
        CLS_GREEN:   px_new = {8'd0, BYTE_FULL, 8'd0};
        CLS_RED:     px_new = {BYTE_FULL, 8'd0, 8'd0};
        default:     px_new = ram_rdata;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_PLOT:  state_next = S_MAP;
            OP_READ:  state_next = S_ADDR;
            OP_CLEAR: state_next = S_CLEAR;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_MAP:   state_next = S_CLAMP;
      S_CLAMP: state_next = S_ADDR;
      S_ADDR:  state_next = S_READ;
      S_READ:  state_next = S_WRITE;
      S_WRITE: state_next = S_IDLE;
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      is_plot    <= 1'b0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      // strobe: end of a memory pass, end of an item's clear, or an unused opcode
      done  <= (state == S_WRITE) ||
               ((state == S_CLEAR) && (clr_addr == ADDR_W'(DEPTH - 1)) && clr_report) ||
               (accept && opcode != OP_PLOT && opcode != OP_READ && opcode != OP_CLEAR);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (accept) begin
        is_plot    <= (opcode == OP_PLOT);
        clr_report <= 1'b1;
        clr_addr   <= '0;
      end
    end
  end

  // Transaction payload and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      x_q   <= pos_x;
      y_q   <= pos_y;
      cls_q <= mark_class;
      // read position saturates to the last column and row
      rd_col_q <= (32'(read_col) >= 32'(IMG_WIDTH))  ? COL_W'(IMG_WIDTH - 1)  :
                                                       COL_W'(read_col);
      rd_row_q <= (32'(read_row) >= 32'(IMG_HEIGHT)) ? ROW_W'(IMG_HEIGHT - 1) :
                                                       ROW_W'(read_row);
      {red, green, blue} <= 24'd0;
    end
    if (state == S_ADDR) begin
      addr_q <= ADDR_W'(32'(row_sel) * 32'(IMG_WIDTH) + 32'(col_sel));
    end
    if (state == S_WRITE) begin
      {red, green, blue} <= px_new;
    end
  end

endmodule

`default_nettype wire

[design/spp_checker.sv]
// Port-level checker for the scatter point plotter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module spp_checker import spp_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] opcode,
  input wire logic [2:0] mark_class,
  input wire logic       done,
  input wire logic [7:0] red,
  input wire logic [7:0] green,
  input wire logic [7:0] blue
);

  // reset always starts the clearing pass
  a_reset_clears: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // a real transaction keeps the block busy and gives no result at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == OP_PLOT || opcode == OP_READ || opcode == OP_CLEAR))
      |=> (busy && !done))
    else $error("accepted transaction did not hold busy");

  // unused opcode answers next cycle with a zero pixel
  a_unused_op: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode != OP_PLOT && opcode != OP_READ && opcode != OP_CLEAR)
      |=> (done && red == 8'd0 && green == 8'd0 && blue == 8'd0))
    else $error("unused opcode result wrong");

  // border plot gives full red and green when its result strobes
  a_border_plot: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_PLOT && mark_class == CLS_BORDER)
      |-> ##6 (done && red == BYTE_FULL && green == BYTE_FULL))
    else $error("border plot result wrong");

  // density plot never leaves red at zero
  a_density_plot: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_PLOT && mark_class == CLS_DENSITY)
      |-> ##6 (done && red != 8'd0 && green == BYTE_FULL && blue == BYTE_FULL))
    else $error("density plot result wrong");

endmodule

bind scatter_point_plotter_core spp_checker u_spp_checker (.*);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the scatter point plotter core: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
  import spp_pkg::*;

  // Image geometry, kept equal to the instance parameters below.
  localparam int IMG_W      = 400;
  localparam int IMG_H      = 400;
  localparam int HALF_SCALE = 200;
  localparam int PIX_SPAN   = IMG_W * IMG_H;

  // Opcode 3 and classes 5..7 have no name in the package.
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [2:0] CLS_KEEP_LO  = 3'd5;
  localparam logic [2:0] CLS_KEEP_HI  = 3'd7;

  localparam int RANDOM_PER_PHASE = 300;
  localparam int HOT_N            = 6;
  localparam int MAX_REPORTS      = 10;
  // Slowest legal run is the clearing pass after reset plus three clears of the
  // whole store; the rest is small. The limit is several times that.
  localparam int CYCLE_LIMIT      = 3_000_000;
  // After the last owed result, watch a bit longer for stray strobes.
  localparam int DRAIN_CYCLES     = 8;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [2:0]         cls;
    logic [8:0]         col;
    logic [8:0]         row;
  } item_t;

  // One line of the directed table: an item, how often to send it, and an
  // optional hand-written pixel that replaces the predicted one.
  typedef struct {
    item_t       it;
    int          reps;
    bit          typed;
    logic [23:0] want;
  } dir_entry_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         opcode;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [2:0]         mark_class;
  logic [8:0]         read_col;
  logic [8:0]         read_row;
  logic               done;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;

  // Mirror of the frame memory and the pixels still owed by the block.
  logic [23:0]        frame_copy [PIX_SPAN];
  logic [23:0]        owed_pixels [$];
  dir_entry_t         directed_plan [$];

  // A few positions that random plots keep hitting, so read-modify-write
  // sees non-zero pixels and back-to-back hits on the same address.
  logic signed [15:0] hot_x [HOT_N];
  logic signed [15:0] hot_y [HOT_N];

  int                 idle_pct;
  int                 err_count = 0;
  int                 cycle_count = 0;

  scatter_point_plotter_core #(
    .IMG_WIDTH  (IMG_W),
    .IMG_HEIGHT (IMG_H),
    .HALF_SCALE (HALF_SCALE)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .mark_class (mark_class),
    .read_col   (read_col),
    .read_row   (read_row),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost strobe ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t ns: %s", $time, msg);
  endfunction

  function automatic void check_byte(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want)
      note_error($sformatf("%s mismatch: expected %h, got %h", name, want, got));
  endfunction

  // trunc(t * HALF_SCALE / 1.0) in Q2.14, with t = coordinate + 1 already
  // folded in; negatives pin to 0, overshoot pins to the last index.
  function automatic logic [8:0] axis_index(int t, int lim);
    int p;
    if (t <= 0)
      return '0;
    p = t * HALF_SCALE / Q_ONE;
    if (p >= lim)
      p = lim - 1;
    return p[8:0];
  endfunction

  // Applies one accepted transaction to the mirror and returns the pixel the
  // block has to report for it.
  function automatic logic [23:0] next_pixel(item_t it);
    int          at;
    logic [8:0]  c;
    logic [8:0]  r;
    logic [7:0]  dens;
    logic [23:0] px;
    px = '0;
    case (it.op)
      OP_PLOT: begin
        c  = axis_index(int'(it.x) + Q_ONE, IMG_W);
        r  = axis_index(Q_ONE - int'(it.y), IMG_H);
        at = r * IMG_W + c;
        px = frame_copy[at];
        case (it.cls)
          CLS_BORDER:  px = {BYTE_FULL, BYTE_FULL, px[7:0]};
          CLS_DENSITY: begin
            // Red counts down and wraps, but never settles on zero.
            dens = px[23:16] - 8'd1;
            if (dens == 8'd0)
              dens = 8'd1;
            px = {dens, BYTE_FULL, BYTE_FULL};
          end
          CLS_BLUE:    px = {16'h0000, BYTE_FULL};
          CLS_GREEN:   px = {8'h00, BYTE_FULL, 8'h00};
          CLS_RED:     px = {BYTE_FULL, 16'h0000};
          default:     ;  // unknown class: pixel reported, left as is
        endcase
        frame_copy[at] = px;
      end
      OP_READ: begin
        c  = (it.col >= IMG_W) ? 9'(IMG_W - 1) : it.col;
        r  = (it.row >= IMG_H) ? 9'(IMG_H - 1) : it.row;
        px = frame_copy[r * IMG_W + c];
      end
      OP_CLEAR: begin
        foreach (frame_copy[i])
          frame_copy[i] = '0;
      end
      default: ;  // unused opcode: zero pixel, no state change
    endcase
    return px;
  endfunction

  function automatic void add_step(logic [1:0] op, int x, int y, logic [2:0] cls,
                                   int col, int row, int reps, bit typed,
                                   logic [23:0] want);
    dir_entry_t e;
    e.it.op  = op;
    e.it.x   = x[15:0];
    e.it.y   = y[15:0];
    e.it.cls = cls;
    e.it.col = col[8:0];
    e.it.row = row[8:0];
    e.reps   = reps;
    e.typed  = typed;
    e.want   = want;
    directed_plan.push_back(e);
  endfunction

  function automatic logic signed [15:0] rand_coord();
    // One in three spans the whole Q2.14 range (clamping), the rest stay on the image.
    if ($urandom_range(2) == 0)
      return 16'($urandom);
    return 16'($urandom_range(32767) - 16384);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    pick;
    int    slot;
    pick   = $urandom_range(99);
    slot   = $urandom_range(HOT_N - 1);
    it.x   = rand_coord();
    it.y   = rand_coord();
    it.cls = 3'($urandom_range(7));
    it.col = 9'($urandom);
    it.row = 9'($urandom);
    if (pick < 3) begin
      it.op = OP_UNUSED;
    end else if (pick < 33) begin
      it.op = OP_READ;
      // Half the reads look at a pixel the plots keep touching.
      if ($urandom_range(1) == 1) begin
        it.col = axis_index(int'(hot_x[slot]) + Q_ONE, IMG_W);
        it.row = axis_index(Q_ONE - int'(hot_y[slot]), IMG_H);
      end
    end else begin
      it.op = OP_PLOT;
      if ($urandom_range(99) < 60) begin
        it.x = hot_x[slot];
        it.y = hot_y[slot];
      end
      if ($urandom_range(99) < 40)
        it.cls = CLS_DENSITY;
      if ($urandom_range(99) < 5) begin
        hot_x[slot] = rand_coord();
        hot_y[slot] = rand_coord();
      end
    end
    return it;
  endfunction

  // Presents one transaction and returns at the edge that accepts it. start is
  // only dropped when an idle gap is taken, so back-to-back items keep it high.
  task automatic send_item(item_t it, bit typed, logic [23:0] want);
    logic [23:0] px;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start      <= 1'b1;
    opcode     <= it.op;
    pos_x      <= it.x;
    pos_y      <= it.y;
    mark_class <= it.cls;
    read_col   <= it.col;
    read_row   <= it.row;
    @(posedge clk);
    while (busy) @(posedge clk);
    px = next_pixel(it);
    owed_pixels.push_back(typed ? want : px);
  endtask

  // Result checker: every strobe must match the oldest owed pixel.
  always @(posedge clk) begin
    logic [23:0] want_px;
    if (!rst && done) begin
      if (owed_pixels.size() == 0) begin
        note_error($sformatf("result %h %h %h with no transaction outstanding",
                             red, green, blue));
      end else begin
        want_px = owed_pixels.pop_front();
        check_byte("red",   want_px[23:16], red);
        check_byte("green", want_px[15:8],  green);
        check_byte("blue",  want_px[7:0],   blue);
      end
    end
  end

  initial begin
    item_t wipe;
    int    phase;

    foreach (frame_copy[i])
      frame_copy[i] = '0;
    rst        = 1'b1;
    start      = 1'b0;
    opcode     = OP_PLOT;
    pos_x      = '0;
    pos_y      = '0;
    mark_class = CLS_BORDER;
    read_col   = '0;
    read_row   = '0;
    idle_pct   = 24;

    // Directed table. Columns: op, x, y, class, read col, read row, repeats,
    // hand-checked flag, hand-checked pixel.
    // Fresh store, including a read far past the image that saturates.
    add_step(OP_READ,  0, 0, CLS_BORDER, 0,   0,   1, 1, 24'h000000);
    add_step(OP_READ,  0, 0, CLS_BORDER, 511, 511, 1, 1, 24'h000000);
    // Most negative x and most positive y land on the top-left corner.
    add_step(OP_PLOT, -32768, 32767, CLS_BORDER, 0, 0, 1, 1, 24'hFFFF00);
    // Opposite extremes clamp to the bottom-right corner; density from zero wraps.
    add_step(OP_PLOT, 32767, -32768, CLS_DENSITY, 0, 0, 1, 1, 24'hFFFFFF);
    add_step(OP_PLOT, 32767, -32768, CLS_DENSITY, 0, 0, 1, 1, 24'hFEFFFF);
    // Every class on the centre pixel, back to back.
    add_step(OP_PLOT, 0, 0, CLS_BLUE,    0, 0, 1, 1, 24'h0000FF);
    add_step(OP_PLOT, 0, 0, CLS_BORDER,  0, 0, 1, 1, 24'hFFFFFF);
    add_step(OP_PLOT, 0, 0, CLS_GREEN,   0, 0, 1, 1, 24'h00FF00);
    add_step(OP_PLOT, 0, 0, CLS_RED,     0, 0, 1, 1, 24'hFF0000);
    add_step(OP_PLOT, 0, 0, CLS_DENSITY, 0, 0, 1, 1, 24'hFEFFFF);
    // Unknown classes report the pixel and leave it alone.
    add_step(OP_PLOT, 0, 0, CLS_KEEP_LO, 0, 0, 1, 1, 24'hFEFFFF);
    add_step(OP_PLOT, 0, 0, CLS_KEEP_HI, 0, 0, 1, 1, 24'hFEFFFF);
    // Unused opcode with all other fields at ones.
    add_step(OP_UNUSED, -1, -1, CLS_KEEP_HI, 511, 511, 1, 1, 24'h000000);
    add_step(OP_READ, 0, 0, CLS_BORDER, 200, 200, 1, 1, 24'hFEFFFF);
    add_step(OP_READ, 0, 0, CLS_BORDER, 399, 399, 1, 1, 24'hFEFFFF);
    add_step(OP_READ, 0, 0, CLS_BORDER, 0,   0,   1, 1, 24'hFFFF00);
    // Density run long enough to count red down to one and pin it there.
    add_step(OP_PLOT, 8192, 8192, CLS_DENSITY, 0, 0, 257, 0, '0);
    // Edges of the mapping: one step into column 1, last column and row.
    add_step(OP_PLOT, -16302, 16384, CLS_GREEN, 0, 0, 1, 0, '0);
    add_step(OP_PLOT, 16383, -16383, CLS_BLUE,  0, 0, 1, 0, '0);
    add_step(OP_READ, 0, 0, CLS_BORDER, 1,   0,   1, 0, '0);
    add_step(OP_READ, 0, 0, CLS_BORDER, 300, 100, 1, 0, '0);
    // Clear, then show the store is empty and density starts over.
    add_step(OP_CLEAR, 0, 0, CLS_BORDER, 0, 0, 1, 1, 24'h000000);
    add_step(OP_READ, 0, 0, CLS_BORDER, 300, 100, 1, 1, 24'h000000);
    add_step(OP_READ, 0, 0, CLS_BORDER, 0,   0,   1, 1, 24'h000000);
    add_step(OP_PLOT, 0, 0, CLS_DENSITY, 0, 0, 1, 1, 24'hFFFFFF);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The first transaction waits out the clearing pass behind busy.
    foreach (directed_plan[i])
      repeat (directed_plan[i].reps)
        send_item(directed_plan[i].it, directed_plan[i].typed, directed_plan[i].want);

    for (int k = 0; k < HOT_N; k++) begin
      hot_x[k] = rand_coord();
      hot_y[k] = rand_coord();
    end

    // Three random phases: light sender gaps, heavy gaps, none. Each later
    // phase opens with a clear so it starts from an empty store.
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 24 : (phase == 1) ? 59 : 0;
      if (phase > 0) begin
        wipe     = rand_item();
        wipe.op  = OP_CLEAR;
        send_item(wipe, 1'b0, '0);
      end
      repeat (RANDOM_PER_PHASE)
        send_item(rand_item(), 1'b0, '0);
    end
    start <= 1'b0;

    while (owed_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
design/spp_pkg.sv
design/spp_axis_map.sv
design/spp_frame_ram.sv
design/scatter_point_plotter_core.sv
design/spp_checker.sv
dv/tb.sv
